// File: src/grid_maze_path_search_top_macros.svh
// Assertion macros for the maze search block.
// Included by grid_maze_path_search_top; expects i_clk and i_rst_n in scope.
`ifndef GRID_MAZE_PATH_SEARCH_TOP_MACROS_SVH
`define GRID_MAZE_PATH_SEARCH_TOP_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define GMPS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("gmps: invariant violated");

// Antecedent implies consequent in the same cycle
`define GMPS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gmps: same-cycle implication violated");

// Antecedent implies consequent in the next cycle
`define GMPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gmps: next-cycle implication violated");

`endif

// File: src/gmps_pkg.sv
// Package for the maze search block: step codes, branch conditions,
// control word layout and the microprogram ROM. No dependencies.
package gmps_pkg;

    localparam int CFG_W = 4;

    // Configuration register indexes
    localparam logic [1:0] REG_START_ROW = 2'd0;
    localparam logic [1:0] REG_START_COL = 2'd1;
    localparam logic [1:0] REG_END_ROW   = 2'd2;
    localparam logic [1:0] REG_END_COL   = 2'd3;

    // Neighbour directions, tried in this order; DIR_DONE means all tried
    localparam logic [2:0] DIR_SOUTH = 3'd0;
    localparam logic [2:0] DIR_WEST  = 3'd1;
    localparam logic [2:0] DIR_NORTH = 3'd2;
    localparam logic [2:0] DIR_EAST  = 3'd3;
    localparam logic [2:0] DIR_DONE  = 3'd4;

    // Microprogram steps
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_TRIV,
        ST_CLR,
        ST_INIT,
        ST_EXPAND,
        ST_TEST,
        ST_POP,
        ST_RESTORE,
        ST_OUT
    } t_step;

    // Branch conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_LAST_ACC,
        C_START_EQ,
        C_START_OUT,
        C_CLR_DONE,
        C_DIR_DONE,
        C_NO_NB,
        C_HIT,
        C_STACK_LAST,
        C_OUT_ACC
    } t_cond;

    // One control word: datapath strobes, two prioritised branches, fall-through
    typedef struct packed {
        logic  in_ready;
        logic  out_valid;
        logic  ld;
        logic  triv;
        logic  clr;
        logic  init;
        logic  tryn;
        logic  test;
        logic  pop;
        logic  restore;
        t_cond cond_a;
        t_step jump_a;
        t_cond cond_b;
        t_step jump_b;
        t_step seq;
    } t_uword;

    // Microprogram ROM
    function automatic t_uword ucode(t_step s);
        t_uword w;
        w        = '0;
        w.cond_a = C_NEVER;
        w.jump_a = ST_LOAD;
        w.cond_b = C_NEVER;
        w.jump_b = ST_LOAD;
        w.seq    = ST_LOAD;
        unique case (s)
            ST_LOAD: begin
                w.in_ready = 1'b1;
                w.ld       = 1'b1;
                w.cond_a   = C_LAST_ACC;
                w.jump_a   = ST_TRIV;
                w.seq      = ST_LOAD;
            end
            ST_TRIV: begin
                w.triv   = 1'b1;
                w.cond_a = C_START_EQ;
                w.jump_a = ST_OUT;
                w.cond_b = C_START_OUT;
                w.jump_b = ST_OUT;
                w.seq    = ST_CLR;
            end
            ST_CLR: begin
                w.clr    = 1'b1;
                w.cond_a = C_CLR_DONE;
                w.jump_a = ST_INIT;
                w.seq    = ST_CLR;
            end
            ST_INIT: begin
                w.init = 1'b1;
                w.seq  = ST_EXPAND;
            end
            ST_EXPAND: begin
                w.tryn   = 1'b1;
                w.cond_a = C_DIR_DONE;
                w.jump_a = ST_POP;
                w.cond_b = C_NO_NB;
                w.jump_b = ST_EXPAND;
                w.seq    = ST_TEST;
            end
            ST_TEST: begin
                w.test   = 1'b1;
                w.cond_a = C_HIT;
                w.jump_a = ST_OUT;
                w.seq    = ST_EXPAND;
            end
            ST_POP: begin
                w.pop    = 1'b1;
                w.cond_a = C_STACK_LAST;
                w.jump_a = ST_OUT;
                w.seq    = ST_RESTORE;
            end
            ST_RESTORE: begin
                w.restore = 1'b1;
                w.seq     = ST_EXPAND;
            end
            ST_OUT: begin
                w.out_valid = 1'b1;
                w.cond_a    = C_OUT_ACC;
                w.jump_a    = ST_LOAD;
                w.seq       = ST_OUT;
            end
            default: begin
                w.seq = ST_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

// File: src/grid_maze_path_search_top.sv
// Maze reachability search: microcoded sequencer, grid/visited/stack memories.
// Depends on gmps_pkg and grid_maze_path_search_top_macros.svh.
`include "grid_maze_path_search_top_macros.svh"

// The grid arrives one cell per transaction in row-major order, one per
// cycle; the cell flagged last starts a depth-first search from the start
// cell to the end cell (neighbours tried south, west, north, east; cells off
// the grid count as walls) and one transaction returns path_found. Start
// equal to end, or a start off the grid, is answered without a search.
// Otherwise a clearing pass sweeps all 2**(clog2(ROWS)+clog2(COLS)) entries
// of the visited map (256 at 16x16), then each neighbour try is a fetch and
// a test step (the fetch alone if it lies off the grid) and each backtrack
// is an exhausted check, a pop and a restore; the grid, visited and stack
// memories have registered reads, one lookup each per step. No new cell is
// taken until the result has been accepted.
module grid_maze_path_search_top #(
    parameter int ROWS = 16,
    parameter int COLS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_cell_open,
    input  logic                      i_last_cell,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_path_found,
    input  logic                      i_cfg_wr_en,
    input  logic [1:0]                i_cfg_addr,
    input  logic [gmps_pkg::CFG_W-1:0] i_cfg_wdata
);
    import gmps_pkg::*;

    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);
    localparam int AW     = RW + CW;
    localparam int SPW    = AW + 1;
    localparam int DEPTH  = 1 << AW;
    localparam int NCELLS = ROWS * COLS;

    // Configuration
    logic [CFG_W-1:0] r_start_row, r_start_col, r_end_row, r_end_col;

    // Sequencer
    t_step   r_step, n_step;
    t_uword  uw;
    logic [15:0] cond_vec;

    // Datapath registers
    logic [RW-1:0]   r_ld_row;
    logic [CW-1:0]   r_ld_col;
    logic [AW-1:0]   r_clr;
    logic [AW-1:0]   r_cur;
    logic [2:0]      r_dir;
    logic [AW-1:0]   r_nb;
    logic [SPW-1:0]  r_sp;
    logic            r_result;

    // Memories
    logic            grid_mem [DEPTH];
    logic            vis_mem  [DEPTH];
    logic [AW+2:0]   stk_mem  [DEPTH];
    logic            r_grid_q;
    logic            r_vis_q;
    logic [AW+2:0]   r_stk_q;

    // Combinational helpers
    logic            in_acc, out_acc;
    logic            start_eq, start_in, end_in;
    logic [AW-1:0]   start_addr, end_addr;
    logic [RW-1:0]   cur_row, nb_row;
    logic [CW-1:0]   cur_col, nb_col;
    logic            nb_ok;
    logic [AW-1:0]   nb_addr;
    logic            open_new, nb_is_end, hit, can_push;
    logic            vis_we, vis_wd;
    logic [AW-1:0]   vis_wa;
    logic            stk_we;
    logic [SPW-1:0]  sp_m1, sp_m2;

    assign uw = ucode(r_step);

    assign in_acc  = i_in_valid & o_in_ready;
    assign out_acc = o_out_valid & i_out_ready;

    // Start / end cell decode; out-of-grid end can never be entered
    assign start_eq   = (r_start_row == r_end_row) && (r_start_col == r_end_col);
    assign start_in   = (32'(r_start_row) < ROWS) && (32'(r_start_col) < COLS);
    assign end_in     = (32'(r_end_row) < ROWS) && (32'(r_end_col) < COLS);
    assign start_addr = {RW'(r_start_row), CW'(r_start_col)};
    assign end_addr   = {RW'(r_end_row), CW'(r_end_col)};

    // Neighbour of the current cell in the current direction
    assign cur_row = r_cur[AW-1:CW];
    assign cur_col = r_cur[CW-1:0];

    always_comb begin
        nb_row = cur_row;
        nb_col = cur_col;
        nb_ok  = 1'b0;
        case (r_dir)
            DIR_SOUTH: begin
                nb_ok  = (cur_row != RW'(ROWS - 1));
                nb_row = cur_row + RW'(1);
            end
            DIR_WEST: begin
                nb_ok  = (cur_col != '0);
                nb_col = cur_col - CW'(1);
            end
            DIR_NORTH: begin
                nb_ok  = (cur_row != '0);
                nb_row = cur_row - RW'(1);
            end
            DIR_EAST: begin
                nb_ok  = (cur_col != CW'(COLS - 1));
                nb_col = cur_col + CW'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign nb_addr = {nb_row, nb_col};

    // Test of the fetched neighbour
    assign open_new  = r_grid_q & ~r_vis_q;
    assign nb_is_end = end_in & (r_nb == end_addr);
    assign hit       = open_new & nb_is_end;
    assign can_push  = r_sp < SPW'(NCELLS);

    assign sp_m1 = r_sp - SPW'(1);
    assign sp_m2 = r_sp - SPW'(2);

    // Branch conditions, indexed by condition code
    always_comb begin
        cond_vec               = '0;
        cond_vec[C_LAST_ACC]   = in_acc & i_last_cell;
        cond_vec[C_START_EQ]   = start_eq;
        cond_vec[C_START_OUT]  = ~start_in;
        cond_vec[C_CLR_DONE]   = &r_clr;
        cond_vec[C_DIR_DONE]   = r_dir[2];
        cond_vec[C_NO_NB]      = ~nb_ok;
        cond_vec[C_HIT]        = hit;
        cond_vec[C_STACK_LAST] = (r_sp == SPW'(1));
        cond_vec[C_OUT_ACC]    = out_acc;
    end

    // Next step and handshake outputs
    always_comb begin
        if (cond_vec[uw.cond_a]) begin
            n_step = uw.jump_a;
        end else if (cond_vec[uw.cond_b]) begin
            n_step = uw.jump_b;
        end else begin
            n_step = uw.seq;
        end
    end

    assign o_in_ready   = uw.in_ready;
    assign o_out_valid  = uw.out_valid;
    assign o_path_found = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_row <= '0;
            r_start_col <= '0;
            r_end_row   <= '0;
            r_end_col   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_START_ROW: r_start_row <= i_cfg_wdata;
                REG_START_COL: r_start_col <= i_cfg_wdata;
                REG_END_ROW:   r_end_row   <= i_cfg_wdata;
                REG_END_COL:   r_end_col   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Load position, wraps at the grid size and restarts after the last cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_row <= '0;
            r_ld_col <= '0;
        end else if (uw.ld && in_acc) begin
            if (i_last_cell) begin
                r_ld_row <= '0;
                r_ld_col <= '0;
            end else if (r_ld_col == CW'(COLS - 1)) begin
                r_ld_col <= '0;
                r_ld_row <= (r_ld_row == RW'(ROWS - 1)) ? '0 : r_ld_row + RW'(1);
            end else begin
                r_ld_col <= r_ld_col + CW'(1);
            end
        end
    end

    // Clearing sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (uw.clr) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // Stack pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (uw.init) begin
            r_sp <= SPW'(1);
        end else if (uw.test && open_new && !nb_is_end && can_push) begin
            r_sp <= r_sp + SPW'(1);
        end else if (uw.pop) begin
            r_sp <= sp_m1;
        end
    end

    // Current cell, direction, fetched neighbour and result
    always_ff @(posedge i_clk) begin
        if (uw.triv) begin
            r_result <= start_eq;
        end
        if (uw.init) begin
            r_cur    <= start_addr;
            r_dir    <= DIR_SOUTH;
            r_result <= 1'b0;
        end
        if (uw.tryn && !r_dir[2]) begin
            r_dir <= r_dir + 3'd1;
            r_nb  <= nb_addr;
        end
        if (uw.test) begin
            if (hit) begin
                r_result <= 1'b1;
            end else if (open_new && can_push) begin
                r_cur <= r_nb;
                r_dir <= DIR_SOUTH;
            end
        end
        if (uw.restore) begin
            r_cur <= r_stk_q[AW+2:3];
            r_dir <= r_stk_q[2:0];
        end
    end

    // Grid store: written during load, read at the neighbour address
    always_ff @(posedge i_clk) begin
        if (uw.ld && in_acc) begin
            grid_mem[{r_ld_row, r_ld_col}] <= i_cell_open;
        end
        r_grid_q <= grid_mem[nb_addr];
    end

    // Visited map write source: sweep, start cell, or newly entered cell
    always_comb begin
        vis_we = 1'b0;
        vis_wa = r_clr;
        vis_wd = 1'b0;
        if (uw.clr) begin
            vis_we = 1'b1;
        end else if (uw.init) begin
            vis_we = 1'b1;
            vis_wa = start_addr;
            vis_wd = 1'b1;
        end else if (uw.test && open_new && !nb_is_end) begin
            vis_we = 1'b1;
            vis_wa = r_nb;
            vis_wd = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            vis_mem[vis_wa] <= vis_wd;
        end
        r_vis_q <= vis_mem[nb_addr];
    end

    // Search stack: entries below the top, which lives in r_cur/r_dir
    assign stk_we = uw.test & open_new & ~nb_is_end & can_push;

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[sp_m1[AW-1:0]] <= {r_cur, r_dir};
        end
        r_stk_q <= stk_mem[sp_m2[AW-1:0]];
    end

    // Checks
    `GMPS_ASSERT_ALWAYS(a_sp_bound, r_sp <= SPW'(NCELLS))
    `GMPS_ASSERT_IMPL(a_no_overlap, o_out_valid, !o_in_ready)
    `GMPS_ASSERT_IMPL(a_stack_live, r_step == ST_EXPAND || r_step == ST_TEST, r_sp != '0)
    `GMPS_ASSERT_NEXT(a_back_to_load, o_out_valid && i_out_ready, o_in_ready && !o_out_valid)

endmodule

// File: tb/grid_maze_path_search_checker.sv
// Checker for the maze search block: watches the cell, answer and register
// ports, predicts each path answer and compares it. Depends on gmps_pkg.
module grid_maze_path_search_checker #(
    parameter int ROWS = 16,
    parameter int COLS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_cell_open,
    input  logic                       i_last_cell,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_path_found,
    input  logic                       i_cfg_wr_en,
    input  logic [1:0]                 i_cfg_addr,
    input  logic [gmps_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic [31:0]                o_fail_count,
    output logic [31:0]                o_pending,
    output logic [31:0]                o_answers,
    output logic [31:0]                o_found
);
    import gmps_pkg::*;

    localparam int NCELLS = ROWS * COLS;

    typedef logic [CFG_W-1:0] t_coord;

    // Shadow of the block's grid and registers
    bit [NCELLS-1:0] floor_map;
    int unsigned     load_pos;
    t_coord          start_row, start_col, goal_row, goal_col;

    // Answers owed by the block, oldest first
    bit              owed_answers[$];
    bit              want;
    int unsigned     errors, answers, found;

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Reachability from start to goal through open cells; the start cell is
    // never tested for being open and cells off the grid count as walls
    function automatic bit path_exists(input bit [NCELLS-1:0] open_map,
                                       input t_coord sr, input t_coord sc,
                                       input t_coord er, input t_coord ec);
        bit [NCELLS-1:0] seen;
        int unsigned     frontier[$];
        int unsigned     cur_cell, goal, r, c, nr, nc, nb;
        logic [2:0]      dir;
        bit              on_grid;
        if (sr == er && sc == ec) begin
            return 1'b1;
        end
        if (sr >= ROWS || sc >= COLS) begin
            return 1'b0;
        end
        goal = (er < ROWS && ec < COLS) ? er * COLS + ec : NCELLS;
        seen = '0;
        seen[sr * COLS + sc] = 1'b1;
        frontier.push_back(sr * COLS + sc);
        while (frontier.size() != 0) begin
            cur_cell = frontier.pop_back();
            r = cur_cell / COLS;
            c = cur_cell % COLS;
            for (dir = DIR_SOUTH; dir != DIR_DONE; dir++) begin
                nr = r;
                nc = c;
                on_grid = 1'b1;
                case (dir)
                    DIR_SOUTH: if (r + 1 < ROWS) nr = r + 1; else on_grid = 1'b0;
                    DIR_WEST:  if (c > 0) nc = c - 1; else on_grid = 1'b0;
                    DIR_NORTH: if (r > 0) nr = r - 1; else on_grid = 1'b0;
                    DIR_EAST:  if (c + 1 < COLS) nc = c + 1; else on_grid = 1'b0;
                    default:   on_grid = 1'b0;
                endcase
                nb = nr * COLS + nc;
                if (on_grid && open_map[nb] && !seen[nb]) begin
                    if (nb == goal) begin
                        return 1'b1;
                    end
                    seen[nb] = 1'b1;
                    frontier.push_back(nb);
                end
            end
        end
        return 1'b0;
    endfunction

    // Track registers and loads, predict on each marked cell, compare answers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_row = '0;
            start_col = '0;
            goal_row  = '0;
            goal_col  = '0;
            load_pos  = 0;
            owed_answers.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_START_ROW: start_row = i_cfg_wdata;
                    REG_START_COL: start_col = i_cfg_wdata;
                    REG_END_ROW:   goal_row  = i_cfg_wdata;
                    REG_END_COL:   goal_col  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                floor_map[load_pos] = i_cell_open;
                if (i_last_cell) begin
                    load_pos = 0;
                    owed_answers.push_back(path_exists(floor_map, start_row, start_col,
                                                       goal_row, goal_col));
                end else begin
                    load_pos = (load_pos + 1) % NCELLS;
                end
            end
            if (i_out_valid && i_out_ready) begin
                answers++;
                if (i_path_found === 1'b1) begin
                    found++;
                end
                if (owed_answers.size() == 0) begin
                    report_mismatch($sformatf("path answer %b with no load pending",
                                              i_path_found));
                end else begin
                    want = owed_answers.pop_front();
                    if (i_path_found !== want) begin
                        report_mismatch($sformatf("path_found %b, predicted %b (answer %0d)",
                                                  i_path_found, want, answers));
                    end
                end
            end
        end
        o_fail_count <= errors;
        o_pending    <= owed_answers.size();
        o_answers    <= answers;
        o_found      <= found;
    end

endmodule

// File: tb/testbench.sv
// Top of the maze search testbench: clock, reset, cell and register stimulus,
// answer back-pressure and the verdict. Depends on gmps_pkg, the block and
// grid_maze_path_search_checker.
module testbench;

    localparam int ROWS          = 16;
    localparam int COLS          = 16;
    localparam int NCELLS        = ROWS * COLS;
    localparam int CELL_TARGET   = 1700;
    localparam int LOAD_TARGET   = 40;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 32;
    localparam int CYCLE_LIMIT   = 20_000_000;

    typedef logic [gmps_pkg::CFG_W-1:0] t_coord;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        cell_open = 1'b0;
    logic        last_cell = 1'b0;
    logic        out_ready = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    t_coord      cfg_wdata = '0;
    logic        in_ready, out_valid, path_found;
    logic [31:0] fail_count, pending, answers, found_answers;

    logic        calm = 1'b0;
    int unsigned cells_sent, loads_sent, settings_used, cycles;

    grid_maze_path_search_top #(.ROWS(ROWS), .COLS(COLS)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_cell_open (cell_open),
        .i_last_cell (last_cell),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_path_found(path_found),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    grid_maze_path_search_checker #(.ROWS(ROWS), .COLS(COLS)) path_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_cell_open (cell_open),
        .i_last_cell (last_cell),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_path_found(path_found),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_answers   (answers),
        .o_found     (found_answers)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d answers outstanding",
                     cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Answer side back-pressure
    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= 8);
    end

    // One cell transaction, with the odd idle cycle in front of it
    task automatic send_cell(input logic open_bit, input logic last_bit);
        while (!calm && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cell_open <= open_bit;
        last_cell <= last_bit;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        cells_sent++;
        if (last_bit) begin
            loads_sent++;
        end
    endtask

    // A load of len cells with the final one marked
    task automatic send_load(input int unsigned len, input int unsigned open_pct);
        for (int unsigned i = 0; i < len; i++) begin
            send_cell($urandom_range(99) < open_pct, i == len - 1);
        end
    endtask

    // Stop sending until every answer owed has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (answers < loads_sent) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input t_coord val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // Registers change only with the block idle
    task automatic set_config(input t_coord sr, input t_coord sc,
                              input t_coord er, input t_coord ec);
        drain();
        write_reg(gmps_pkg::REG_START_ROW, sr);
        write_reg(gmps_pkg::REG_START_COL, sc);
        write_reg(gmps_pkg::REG_END_ROW, er);
        write_reg(gmps_pkg::REG_END_COL, ec);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Coordinate biased toward the grid edges
    function automatic t_coord pick_coord();
        if ($urandom_range(3) == 0) begin
            return $urandom_range(1) ? '1 : '0;
        end
        return t_coord'($urandom_range(ROWS - 1));
    endfunction

    initial begin
        int unsigned   batch, len, pick;
        t_coord        sr, sc, er, ec;
        int unsigned   densities[5];
        densities = '{50, 65, 80, 92, 100};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Start equals goal at the reset settings: answered without the grid
        send_cell(1'b0, 1'b1);

        // Full grid split by a wall in column 8: no way across
        set_config('0, '0, '1, '1);
        for (int unsigned i = 0; i < NCELLS; i++) begin
            send_cell((i % COLS) != 8, i == NCELLS - 1);
        end
        // Short load opens the gap at the top of the wall
        for (int unsigned i = 0; i < 9; i++) begin
            send_cell(1'b1, i == 8);
        end
        // Start cell turned into a wall: search still leaves it
        send_cell(1'b0, 1'b1);
        // Goal cell a wall
        set_config('0, '0, '0, 4'd1);
        send_cell(1'b1, 1'b0);
        send_cell(1'b0, 1'b1);
        // Start equals goal in the far corner
        set_config('1, '1, '1, '1);
        send_cell(1'b1, 1'b1);
        // Opposite corners, winding round the wall
        set_config('1, '0, '0, '1);
        send_cell(1'b1, 1'b1);

        // Random loads: mostly short rewrites of the top row, some full
        // grids and some that run past the end and wrap
        batch = 0;
        while (cells_sent < CELL_TARGET || loads_sent < LOAD_TARGET) begin
            if (batch % 3 == 0) begin
                sr = pick_coord();
                sc = pick_coord();
                er = pick_coord();
                ec = pick_coord();
                if ($urandom_range(99) < 12) begin
                    er = sr;
                    ec = sc;
                end
                set_config(sr, sc, er, ec);
            end
            calm <= (batch >= 10 && batch < 20);
            pick = $urandom_range(99);
            if (pick < 75) begin
                len = $urandom_range(16, 1);
            end else if (pick < 87) begin
                len = $urandom_range(NCELLS - 1, 17);
            end else if (pick < 96) begin
                len = NCELLS;
            end else begin
                len = $urandom_range(NCELLS + 44, NCELLS + 1);
            end
            send_load(len, densities[$urandom_range(4)]);
            batch++;
        end
        calm <= 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d cells in %0d loads under %0d start/goal settings",
                 cells_sent, loads_sent, settings_used);
        $display("%0d answers compared: %0d with a path, %0d without",
                 answers, found_answers, answers - found_answers);
        if (pending != 0) begin
            $display("%0d predicted answers never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
